// ===== sv/can_over_uart_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// CAN-over-UART receiver assertion macros
// Shorthand for clocked, reset-gated property checks.
// ----------------------------------------------------------------------------
`ifndef CAN_OVER_UART_FRAME_RECEIVER_MACROS_SVH
`define CAN_OVER_UART_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define COUR_ASSERT_NOW(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define COUR_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cour_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cour_pkg
// Shared types and constants of the CAN-over-UART frame receiver.
// ----------------------------------------------------------------------------
package cour_pkg;

  localparam int ID_W      = 29;
  localparam int DLC_W     = 4;
  localparam int PAY_BYTES = 8;
  localparam int PAY_W     = PAY_BYTES * 8;

  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [7:0]  END_BYTE   = 8'h55;
  localparam logic [7:0]  EXT_FLAG   = 8'h80;
  localparam logic [7:0]  EXT_MASK   = 8'h1F;
  localparam logic [7:0]  STD_MASK   = 8'h07;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] TMO_RESET  = 16'd1000;

  typedef enum logic [1:0] {
    ST_OK,
    ST_CRC,
    ST_FRAME,
    ST_TIMEOUT
  } status_t;

  typedef struct packed {
    status_t            status;
    logic               extended;
    logic [ID_W-1:0]    msg_id;
    logic [DLC_W-1:0]   data_len;
    logic [PAY_W-1:0]   payload;
  } res_t;

  typedef struct packed {
    logic       init;
    logic       load;
    logic [7:0] din;
  } crc_ctl_t;

endpackage

// ===== sv/cour_crc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cour_crc
// Bit-serial CRC-16 (reflected 0xA001), one bit per cycle from a byte shifter.
// ----------------------------------------------------------------------------
module cour_crc import cour_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  crc_ctl_t      ctl,
  output logic          busy,
  output logic [15:0]   crc
);

  logic [7:0]  sh;
  logic [3:0]  bits;
  logic        fb;
  logic [15:0] crc_next;

  assign fb       = crc[0] ^ sh[0];
  assign crc_next = {1'b0, crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
  assign busy     = (bits != 4'd0) || ctl.load;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= 4'd0;
    end else if (ctl.init) begin
      crc  <= CRC_INIT;
      bits <= 4'd0;
    end else if (ctl.load) begin
      sh   <= ctl.din;
      bits <= 4'd8;
    end else if (bits != 4'd0) begin
      crc  <= crc_next;
      sh   <= {1'b0, sh[7:1]};
      bits <= bits - 4'd1;
    end
  end

endmodule

// ===== sv/cour_frame_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cour_frame_dec
// Frame store and decode sequencer: walks the stored bytes one per step,
// builds ID, DLC and payload, and feeds the serial CRC unit.
// ----------------------------------------------------------------------------
module cour_frame_dec import cour_pkg::*; #(
  parameter int FRAME_BYTES = 16,
  parameter int MAX_PAYLOAD = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic                           start,
  input  logic [$clog2(FRAME_BYTES)-1:0] end_idx,
  output logic                           busy,
  output logic                           done,
  output res_t                           res
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] POS_STD = CW'(3);
  localparam logic [CW-1:0] POS_EXT = CW'(5);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_USE,
    S_PRE,
    S_CHECK
  } state_t;

  logic [7:0]       store [FRAME_BYTES];
  logic [7:0]       rdata;
  state_t           state;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    e_idx;
  logic             ext;
  logic [1:0]       pre_cnt;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    dend;
  logic [ID_W-1:0]  id;
  logic [DLC_W-1:0] dlc;
  logic [PAY_W-1:0] pay;
  logic [2:0]       di;
  logic [7:0]       rx_hi;
  logic [7:0]       rx_lo;
  crc_ctl_t         crc_ctl;
  logic             crc_busy;
  logic [15:0]      crc;

  logic [CW-1:0]    addr_x;
  logic [CW-1:0]    e_x;
  logic [CW-1:0]    pos_new;
  logic [3:0]       n_new;
  logic [CW-1:0]    need;
  logic [7:0]       hdr_masked;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rdata <= store[addr];
  end

  assign busy       = (state != S_IDLE);
  assign addr_x     = {1'b0, addr};
  assign e_x        = {1'b0, e_idx};
  assign pos_new    = rdata[7] ? POS_EXT : POS_STD;
  assign n_new      = (rdata[3:0] < 4'(MAX_PAYLOAD)) ? rdata[3:0] : 4'(MAX_PAYLOAD);
  assign need       = pos + CW'(n_new) + CW'(3);
  assign hdr_masked = ext ? (rdata & EXT_MASK) : (rdata & STD_MASK);

  cour_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .busy (crc_busy),
    .crc  (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      crc_ctl <= '0;
    end else begin
      done         <= 1'b0;
      crc_ctl.load <= 1'b0;
      crc_ctl.init <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            addr         <= AW'(1);
            e_idx        <= end_idx;
            id           <= '0;
            pay          <= '0;
            di           <= 3'd0;
            crc_ctl.init <= 1'b1;
            state        <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_USE;
        end
        S_USE: begin
          if (addr == AW'(1)) begin
            ext     <= rdata[7];
            pos     <= pos_new;
            pre_cnt <= rdata[7] ? 2'd1 : 2'd3;
            if (pos_new >= e_x) begin
              done  <= 1'b1;
              res   <= '{status: ST_FRAME, default: '0};
              state <= S_IDLE;
            end else begin
              state <= S_PRE;
            end
          end else if (!crc_busy) begin
            priority if (addr_x < pos) begin
              crc_ctl.load <= 1'b1;
              crc_ctl.din  <= rdata;
              id           <= {id[ID_W-9:0], rdata};
              addr         <= addr + AW'(1);
              state        <= S_FETCH;
            end else if (addr_x == pos) begin
              dlc <= rdata[3:0];
              if (need > e_x) begin
                done  <= 1'b1;
                res   <= '{status: ST_FRAME, default: '0};
                state <= S_IDLE;
              end else begin
                crc_ctl.load <= 1'b1;
                crc_ctl.din  <= {4'h0, rdata[3:0]};
                dend         <= pos + CW'(n_new);
                addr         <= addr + AW'(1);
                state        <= S_FETCH;
              end
            end else if (addr_x <= dend) begin
              crc_ctl.load       <= 1'b1;
              crc_ctl.din        <= rdata;
              pay[{di, 3'b000} +: 8] <= rdata;
              di                 <= di + 3'd1;
              addr               <= addr + AW'(1);
              state              <= S_FETCH;
            end else if (addr_x == dend + CW'(1)) begin
              rx_hi <= rdata;
              addr  <= addr + AW'(1);
              state <= S_FETCH;
            end else begin
              rx_lo <= rdata;
              state <= S_CHECK;
            end
          end
        end
        S_PRE: begin
          if (!crc_busy) begin
            crc_ctl.load <= 1'b1;
            if (pre_cnt != 2'd0) begin
              // flag byte for an extended ID, zero high ID bytes for a standard ID
              crc_ctl.din <= ext ? EXT_FLAG : 8'h00;
              pre_cnt     <= pre_cnt - 2'd1;
            end else begin
              crc_ctl.din <= hdr_masked;
              id          <= ID_W'(hdr_masked);
              addr        <= addr + AW'(1);
              state       <= S_FETCH;
            end
          end
        end
        S_CHECK: begin
          if (!crc_busy) begin
            done         <= 1'b1;
            res.status   <= (crc == {rx_hi, rx_lo}) ? ST_OK : ST_CRC;
            res.extended <= ext;
            res.msg_id   <= id;
            res.data_len <= dlc;
            res.payload  <= pay;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/can_over_uart_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_over_uart_frame_receiver
// Hunts for 0xAA, collects a frame up to 0x55 or a full store, then decodes
// ID, DLC and data and checks a CRC-16; also times out on ticks.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | req_type, rx_byte
//   out     | output    | out_valid/out_ready | status, extended, msg_id,
//           |           |                     | data_len, payload
//   cfg     | input     | cfg_valid/cfg_ready | cfg_data (timeout_limit)
//
// Ticks and bytes are taken whenever in_ready is high; timeout and store-full
// results appear the cycle after the transfer.
// After an end byte the decoder feeds every CRC byte through the bit-serial
// CRC unit; the longest frame has 14 CRC bytes (standard ID with 8 data
// bytes; an extended ID fits at most 7 data bytes, giving 13).
// in_ready is low from the end byte until the result is out.
// A waiting result does not block input if it is taken in the same cycle.
// Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "can_over_uart_frame_receiver_macros.svh"

module can_over_uart_frame_receiver import cour_pkg::*; #(
  parameter int FRAME_BYTES = 16,
  parameter int MAX_PAYLOAD = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic              extended,
  output logic [ID_W-1:0]   msg_id,
  output logic [DLC_W-1:0]  data_len,
  output logic [PAY_W-1:0]  payload,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  localparam int AW = $clog2(FRAME_BYTES);

  logic [15:0]   timeout_limit;
  logic          collecting;
  logic [AW-1:0] byte_count;
  logic [15:0]   wait_count;
  res_t          out_res;

  logic          accept;
  logic          is_start;
  logic          count_evt;
  logic          store_evt;
  logic          last;
  logic          frame_bad;
  logic [16:0]   wait_inc;
  logic          tmo;
  logic          frm;
  logic          dec_start;
  logic          dec_busy;
  logic          dec_done;
  res_t          dec_res;
  logic [AW-1:0] wr_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = !dec_busy && !dec_done && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign is_start  = !req_type && (rx_byte == START_BYTE);
  assign count_evt = accept && (collecting ? req_type : !is_start);
  assign store_evt = accept && !req_type && (collecting || is_start);
  assign last      = accept && collecting && !req_type &&
                     ((rx_byte == END_BYTE) || (byte_count == AW'(FRAME_BYTES - 1)));
  assign frame_bad = (rx_byte != END_BYTE);
  assign wait_inc  = {1'b0, wait_count} + 17'd1;
  assign tmo       = count_evt && (wait_inc >= {1'b0, timeout_limit});
  assign frm       = last && frame_bad;
  assign dec_start = last && !frame_bad;
  assign wr_addr   = collecting ? byte_count : '0;

  cour_frame_dec #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dec (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_evt),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .start   (dec_start),
    .end_idx (byte_count),
    .busy    (dec_busy),
    .done    (dec_done),
    .res     (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TMO_RESET;
      collecting    <= 1'b0;
      byte_count    <= '0;
      wait_count    <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_limit <= cfg_data;
      end
      if (tmo || frm || dec_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        priority if (tmo || last) begin
          collecting <= 1'b0;
          byte_count <= '0;
          wait_count <= 16'd0;
        end else if (count_evt) begin
          wait_count <= wait_inc[15:0];
        end else if (store_evt) begin
          collecting <= 1'b1;
          byte_count <= collecting ? byte_count + AW'(1) : AW'(1);
        end else begin
          collecting <= collecting;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tmo) begin
      out_res <= '{status: ST_TIMEOUT, default: '0};
    end else if (frm) begin
      out_res <= '{status: ST_FRAME, default: '0};
    end else if (dec_done) begin
      out_res <= dec_res;
    end
  end

  assign status   = out_res.status;
  assign extended = out_res.extended;
  assign msg_id   = out_res.msg_id;
  assign data_len = out_res.data_len;
  assign payload  = out_res.payload;

  `COUR_ASSERT_NOW(a_no_input_while_decoding, clk, rst, dec_busy, !in_ready, "input taken during decode")
  `COUR_ASSERT_NEXT(a_start_resets_collect, clk, rst, dec_start, dec_busy && !collecting && byte_count == '0, "decode start did not return to hunting")
  `COUR_ASSERT_NOW(a_timeout_fields_zero, clk, rst, out_valid && out_res.status == ST_TIMEOUT, out_res.msg_id == '0 && out_res.payload == '0 && !out_res.extended, "timeout result carries data")
  `COUR_ASSERT_NOW(a_frame_fields_zero, clk, rst, out_valid && out_res.status == ST_FRAME, out_res.msg_id == '0 && out_res.data_len == '0 && out_res.payload == '0, "framing result carries data")

endmodule
